/* design/tpq_pkg.sv */
// ----------------------------------------------------------------------------
// tpq_pkg
// shared types, codes and the priority compare of the two-key priority queue
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int TAG_W            = 32;
    localparam int ROLL_W           = 16;
    localparam int MARK_W           = 10;
    localparam int REC_W            = TAG_W + ROLL_W + MARK_W;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_TOP    = 2'd2,
        OP_POP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_PLACE,
        ST_FIN,
        ST_REPORT_RD,
        ST_REPORT_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [TAG_W-1:0]  name_tag;
        logic [ROLL_W-1:0] roll_number;
        logic [MARK_W-1:0] mark_value;
    } req_t;

    typedef struct packed {
        logic              is_empty;
        logic              overflow;
        logic [TAG_W-1:0]  top_tag;
        logic [ROLL_W-1:0] top_roll;
        logic [MARK_W-1:0] top_mark;
    } rsp_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [ROLL_W-1:0] roll;
        logic [MARK_W-1:0] mark;
    } rec_t;

    // true when x strictly outranks y: higher mark, then lower roll
    function automatic logic outranks(input rec_t x, input rec_t y);
        logic res;
        if (x.mark != y.mark)
        begin
            res = (x.mark > y.mark);
        end
        else
        begin
            res = (x.roll < y.roll);
        end
        return res;
    endfunction

endpackage

/* design/tpq_ram.sv */
// ----------------------------------------------------------------------------
// tpq_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tpq_ram #(
    parameter int WIDTH = tpq_pkg::REC_W,
    parameter int DEPTH = tpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/two_key_max_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// two_key_max_priority_queue_top
// bounded max-priority queue of records kept sorted in a circular ram
// ----------------------------------------------------------------------------
// usage:
//   a command transfer happens when start is high and busy is low; req holds
//   op, name_tag, roll_number and mark_value. load (op 0) gives no result;
//   insert, top and pop each give one result on rsp, marked by done for
//   exactly one cycle. the receiver cannot stall; done is never held.
//   records sit sorted, top first, in a ring of CAPACITY entries. pop moves
//   the head pointer and lowers the fill count. insert and load walk back from
//   the tail with one shared compare unit, moving each lower-ranked record up
//   one slot; each record passed takes a read and a compare state, as the
//   compare waits on the registered ram read. insert and load then go to place
//   if all held records were passed, then to finish; a full queue goes straight to
//   finish. load goes back to idle from finish; insert, top and pop end
//   with the report read and report output states.
//   busy falls in the cycle done is high, so the next transfer can be taken
//   while the result is on rsp.
//   reset empties the queue at once (fill count and head cleared); ram
//   contents are not cleared and are never shown unless written.
// ----------------------------------------------------------------------------
module two_key_max_priority_queue_top #(
    parameter int CAPACITY = tpq_pkg::DEFAULT_CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tpq_pkg::req_t req,
    output logic          done,
    output tpq_pkg::rsp_t rsp
);

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W   = COUNT_W + 1;

    tpq_pkg::state_t     state_reg, state_next;
    tpq_pkg::op_t        op_reg, op_next;
    tpq_pkg::rec_t       rec_reg, rec_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic                ovf_reg, ovf_next;
    tpq_pkg::rsp_t       rsp_reg, rsp_next;
    logic                done_reg, done_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [tpq_pkg::REC_W-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [tpq_pkg::REC_W-1:0] ram_rdata;
    tpq_pkg::rec_t         rd_rec;

    logic [ADDR_W-1:0]   idx_up;
    logic [ADDR_W-1:0]   idx_dn;
    logic [ADDR_W-1:0]   head_up;
    logic [SUM_W-1:0]    tail_sum;
    logic [ADDR_W-1:0]   tail_idx;
    logic                is_full;

    tpq_ram #(
        .WIDTH (tpq_pkg::REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rec  = tpq_pkg::rec_t'(ram_rdata);
    assign idx_up  = (idx_reg == ADDR_W'(CAPACITY - 1)) ? '0 : idx_reg + ADDR_W'(1);
    assign idx_dn  = (idx_reg == '0) ? ADDR_W'(CAPACITY - 1) : idx_reg - ADDR_W'(1);
    assign head_up = (head_reg == ADDR_W'(CAPACITY - 1)) ? '0 : head_reg + ADDR_W'(1);
    assign is_full = (count_reg == COUNT_W'(CAPACITY));

    // address of the last record in the ring
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1);
        if (tail_sum >= SUM_W'(CAPACITY))
        begin
            tail_sum = tail_sum - SUM_W'(CAPACITY);
        end
        tail_idx = tail_sum[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpq_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rec_reg  <= rec_next;
        idx_reg  <= idx_next;
        left_reg <= left_next;
        ovf_reg  <= ovf_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        rec_next   = rec_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        left_next  = left_reg;
        ovf_next   = ovf_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_up;
        ram_wdata  = rec_reg;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg;

        case (state_reg)
            tpq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = tpq_pkg::op_t'(req.op);
                    rec_next.tag  = req.name_tag;
                    rec_next.roll = req.roll_number;
                    rec_next.mark = req.mark_value;
                    ovf_next      = 1'b0;
                    case (tpq_pkg::op_t'(req.op))
                        tpq_pkg::OP_LOAD, tpq_pkg::OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                // dropped; only an insert flags it
                                ovf_next   = (tpq_pkg::op_t'(req.op) == tpq_pkg::OP_INSERT);
                                state_next = tpq_pkg::ST_FIN;
                            end
                            else if (count_reg == '0)
                            begin
                                idx_next   = head_reg;
                                state_next = tpq_pkg::ST_PLACE;
                            end
                            else
                            begin
                                idx_next   = tail_idx;
                                left_next  = count_reg;
                                state_next = tpq_pkg::ST_SCAN_RD;
                            end
                        end
                        tpq_pkg::OP_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                head_next  = head_up;
                                count_next = count_reg - COUNT_W'(1);
                            end
                            state_next = tpq_pkg::ST_REPORT_RD;
                        end
                        default:
                        begin
                            state_next = tpq_pkg::ST_REPORT_RD;
                        end
                    endcase
                end
            end

            tpq_pkg::ST_SCAN_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = tpq_pkg::ST_SCAN_CMP;
            end

            tpq_pkg::ST_SCAN_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_up;
                if (tpq_pkg::outranks(rec_reg, rd_rec))
                begin
                    // move the lower-ranked record up one slot
                    ram_wdata = rd_rec;
                    left_next = left_reg - COUNT_W'(1);
                    if (left_reg == COUNT_W'(1))
                    begin
                        state_next = tpq_pkg::ST_PLACE;
                    end
                    else
                    begin
                        idx_next   = idx_dn;
                        state_next = tpq_pkg::ST_SCAN_RD;
                    end
                end
                else
                begin
                    ram_wdata  = rec_reg;
                    count_next = count_reg + COUNT_W'(1);
                    state_next = tpq_pkg::ST_FIN;
                end
            end

            tpq_pkg::ST_PLACE:
            begin
                // new record lands at the head slot
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = rec_reg;
                count_next = count_reg + COUNT_W'(1);
                state_next = tpq_pkg::ST_FIN;
            end

            tpq_pkg::ST_FIN:
            begin
                if (op_reg == tpq_pkg::OP_LOAD)
                begin
                    state_next = tpq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tpq_pkg::ST_REPORT_RD;
                end
            end

            tpq_pkg::ST_REPORT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = head_reg;
                state_next = tpq_pkg::ST_REPORT_OUT;
            end

            tpq_pkg::ST_REPORT_OUT:
            begin
                rsp_next.overflow = ovf_reg;
                if (count_reg == '0)
                begin
                    rsp_next.is_empty = 1'b1;
                    rsp_next.top_tag  = '0;
                    rsp_next.top_roll = '0;
                    rsp_next.top_mark = '0;
                end
                else
                begin
                    rsp_next.is_empty = 1'b0;
                    rsp_next.top_tag  = rd_rec.tag;
                    rsp_next.top_roll = rd_rec.roll;
                    rsp_next.top_mark = rd_rec.mark;
                end
                done_next  = 1'b1;
                state_next = tpq_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = tpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != tpq_pkg::ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result driven while still working");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not start work");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.is_empty == (count_reg == '0)))
        else $error("empty flag disagrees with fill count");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.overflow) |-> (!rsp.is_empty && is_full))
        else $error("overflow reported on a queue that is not full");

endmodule

/* sim/two_key_max_priority_queue_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_key_max_priority_queue_top_tb
// The testbench runs a directed table and then biased random command streams
// through the queue. The stimulus fills the queue, drains it, and works on
// equal keys. Each result is checked field by field, on typed directed rows
// against the row's own value, else against the testbench's sorted-array model.
// ----------------------------------------------------------------------------
module two_key_max_priority_queue_top_tb;

    localparam int CAPACITY     = tpq_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_ITEMS   = 150;
    localparam int TAIL_CYCLES  = 6 + 2 * CAPACITY + 20;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SCRIPT_ROWS  = 21;

    localparam tpq_pkg::rsp_t RSP_NONE  = '0;
    localparam tpq_pkg::rsp_t RSP_EMPTY = '{1'b1, 1'b0, 32'h0, 16'h0, 10'h0};

    typedef struct {
        tpq_pkg::op_t                op;
        logic [tpq_pkg::TAG_W-1:0]   tag;
        logic [tpq_pkg::ROLL_W-1:0]  roll;
        logic [tpq_pkg::MARK_W-1:0]  mark;
        int                          reps;
        bit                          typed;
        tpq_pkg::rsp_t               want;
    } script_row_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    tpq_pkg::req_t req;
    logic          done;
    tpq_pkg::rsp_t rsp;

    // model of the queue: sorted, top first
    tpq_pkg::rec_t held_recs [CAPACITY];
    int unsigned   held_count;

    tpq_pkg::rsp_t expected_tops [$];
    tpq_pkg::rsp_t want_rsp;
    int            mismatch_count;

    // fields of the directed rows for op 2 and op 3 are garbage on purpose
    script_row_t script [SCRIPT_ROWS] = '{
        '{tpq_pkg::OP_TOP,    32'h0000_0000, 16'h0000, 10'h000, 1,  1'b1, RSP_EMPTY},
        '{tpq_pkg::OP_POP,    32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 1,  1'b1, RSP_EMPTY},
        '{tpq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h0000, 10'h3FF, 1,  1'b1,
            '{1'b0, 1'b0, 32'hFFFF_FFFF, 16'h0000, 10'h3FF}},
        '{tpq_pkg::OP_INSERT, 32'h0000_0000, 16'hFFFF, 10'h000, 1,  1'b1,
            '{1'b0, 1'b0, 32'hFFFF_FFFF, 16'h0000, 10'h3FF}},
        '{tpq_pkg::OP_LOAD,   32'h1234_5678, 16'h0005, 10'h3FF, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_INSERT, 32'h0000_AAAA, 16'h0000, 10'h3FF, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_TOP,    32'h5A5A_5A5A, 16'hA5A5, 10'h155, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_POP,    32'h0000_0000, 16'h0000, 10'h000, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_POP,    32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_INSERT, 32'h0000_BBBB, 16'h0005, 10'h200, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_INSERT, 32'h0000_CCCC, 16'h0004, 10'h200, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_POP,    32'h0000_0000, 16'h0000, 10'h000, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_POP,    32'h0000_0000, 16'h0000, 10'h000, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_POP,    32'h0000_0000, 16'h0000, 10'h000, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_LOAD,   32'h4000_0000, 16'h0100, 10'h180, 64, 1'b0, RSP_NONE},
        '{tpq_pkg::OP_INSERT, 32'hDEAD_BEEF, 16'h0000, 10'h3FF, 1,  1'b1,
            '{1'b0, 1'b1, 32'h4000_0000, 16'h0100, 10'h180}},
        '{tpq_pkg::OP_LOAD,   32'h0000_0000, 16'h0000, 10'h3FF, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_TOP,    32'h0000_0000, 16'h0000, 10'h000, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_POP,    32'h0000_0000, 16'h0000, 10'h000, 64, 1'b0, RSP_NONE},
        '{tpq_pkg::OP_INSERT, 32'h0000_0001, 16'h0000, 10'h000, 1,  1'b0, RSP_NONE},
        '{tpq_pkg::OP_POP,    32'h0000_0000, 16'h0000, 10'h000, 1,  1'b1, RSP_EMPTY}
    };

    two_key_max_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit ranks_above(input tpq_pkg::rec_t a, input tpq_pkg::rec_t b);
        if (a.mark != b.mark)
        begin
            return a.mark > b.mark;
        end
        return a.roll < b.roll;
    endfunction

    // updates the queue model; returns 1 when the command gives a result
    function automatic bit apply_cmd(input tpq_pkg::op_t op, input tpq_pkg::rec_t rec,
                                     output tpq_pkg::rsp_t res);
        bit          stored;
        int unsigned pos;
        int unsigned i;
        stored = 1'b1;
        case (op)
            tpq_pkg::OP_LOAD, tpq_pkg::OP_INSERT:
            begin
                if (held_count >= CAPACITY)
                begin
                    stored = 1'b0;
                end
                else
                begin
                    pos = 0;
                    // equal keys go behind the ones already held
                    while (pos < held_count && !ranks_above(rec, held_recs[pos]))
                    begin
                        pos++;
                    end
                    for (i = held_count; i > pos; i--)
                    begin
                        held_recs[i] = held_recs[i-1];
                    end
                    held_recs[pos] = rec;
                    held_count++;
                end
            end
            tpq_pkg::OP_POP:
            begin
                if (held_count != 0)
                begin
                    for (i = 1; i < held_count; i++)
                    begin
                        held_recs[i-1] = held_recs[i];
                    end
                    held_count--;
                end
            end
            default:
            begin
            end
        endcase
        res          = '0;
        res.is_empty = (held_count == 0);
        res.overflow = !stored;
        if (held_count != 0)
        begin
            res.top_tag  = held_recs[0].tag;
            res.top_roll = held_recs[0].roll;
            res.top_mark = held_recs[0].mark;
        end
        return op != tpq_pkg::OP_LOAD;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // call right after clk rises; returns when the transfer is taken
    task automatic send_cmd(input tpq_pkg::op_t op, input logic [tpq_pkg::TAG_W-1:0] tag,
                            input logic [tpq_pkg::ROLL_W-1:0] roll,
                            input logic [tpq_pkg::MARK_W-1:0] mark,
                            input bit typed, input tpq_pkg::rsp_t want);
        tpq_pkg::req_t cmd;
        tpq_pkg::rec_t rec;
        tpq_pkg::rsp_t predicted;
        cmd.op          = op;
        cmd.name_tag    = tag;
        cmd.roll_number = roll;
        cmd.mark_value  = mark;
        start <= 1'b1;
        req   <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        rec.tag  = tag;
        rec.roll = roll;
        rec.mark = mark;
        if (apply_cmd(op, rec, predicted))
        begin
            expected_tops.push_back(typed ? want : predicted);
        end
    endtask

    task automatic maybe_idle(input bit allowed);
        int gap;
        if (allowed && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_tops.size() == 0)
            begin
                report_mismatch("result with no command waiting for one");
            end
            else
            begin
                want_rsp = expected_tops.pop_front();
                if (rsp.is_empty !== want_rsp.is_empty)
                    report_mismatch($sformatf("is_empty %b, want %b",
                                              rsp.is_empty, want_rsp.is_empty));
                if (rsp.overflow !== want_rsp.overflow)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              rsp.overflow, want_rsp.overflow));
                if (rsp.top_tag !== want_rsp.top_tag)
                    report_mismatch($sformatf("top_tag %h, want %h",
                                              rsp.top_tag, want_rsp.top_tag));
                if (rsp.top_roll !== want_rsp.top_roll)
                    report_mismatch($sformatf("top_roll %h, want %h",
                                              rsp.top_roll, want_rsp.top_roll));
                if (rsp.top_mark !== want_rsp.top_mark)
                    report_mismatch($sformatf("top_mark %h, want %h",
                                              rsp.top_mark, want_rsp.top_mark));
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int                          row;
        int                          k;
        int                          n;
        int                          mode;
        int                          pick;
        bit                          idle_on;
        tpq_pkg::op_t                op;
        logic [tpq_pkg::TAG_W-1:0]   tag;
        logic [tpq_pkg::ROLL_W-1:0]  roll;
        logic [tpq_pkg::MARK_W-1:0]  mark;

        mismatch_count = 0;
        held_count     = 0;
        mode           = 2;
        idle_on        = 1'b1;
        rst_n   = 1'b0;
        start  <= 1'b0;
        req    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < SCRIPT_ROWS; row++)
        begin
            for (k = 0; k < script[row].reps; k++)
            begin
                send_cmd(script[row].op, tpq_pkg::TAG_W'(script[row].tag + k),
                         tpq_pkg::ROLL_W'(script[row].roll + k),
                         script[row].mark, script[row].typed, script[row].want);
                maybe_idle(1'b1);
            end
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // grow, shrink or mixed phases so the queue swings between full and empty
            if (n % 60 == 0)
            begin
                mode    = $urandom_range(0, 2);
                idle_on = ($urandom_range(0, 2) != 0);
            end
            if (n == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                while (expected_tops.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            case (mode)
                0:       op = pick < 35 ? tpq_pkg::OP_LOAD : pick < 80 ? tpq_pkg::OP_INSERT :
                              pick < 90 ? tpq_pkg::OP_TOP : tpq_pkg::OP_POP;
                1:       op = pick < 10 ? tpq_pkg::OP_LOAD : pick < 25 ? tpq_pkg::OP_INSERT :
                              pick < 40 ? tpq_pkg::OP_TOP : tpq_pkg::OP_POP;
                default: op = tpq_pkg::op_t'(2'(pick % 4));
            endcase
            // narrow keys make ties on mark and on both keys common
            if ($urandom_range(0, 1) == 1)
            begin
                mark = tpq_pkg::MARK_W'($urandom_range(0, 3) * 341);
                roll = tpq_pkg::ROLL_W'($urandom_range(0, 3));
            end
            else
            begin
                mark = tpq_pkg::MARK_W'($urandom_range(0, 1023));
                roll = tpq_pkg::ROLL_W'($urandom_range(0, 65535));
            end
            tag = $urandom();
            send_cmd(op, tag, roll, mark, 1'b0, RSP_NONE);
            maybe_idle(idle_on && n < RANDOM_ITEMS - CALM_ITEMS);
        end

        start <= 1'b0;
        while (expected_tops.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
